// File: sv/kmp_substring_matcher_defines.svh
// ----------------------------------------------------------------------------
// KMP substring matcher assertion macros
// Shared property wrappers for the checker of the substring matcher.
// ----------------------------------------------------------------------------
`ifndef KMP_SUBSTRING_MATCHER_DEFINES_SVH
`define KMP_SUBSTRING_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define KMP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KMP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/kmp_pkg.sv
// ----------------------------------------------------------------------------
// KMP substring matcher package
// Types, codes and helpers shared by the matcher and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package kmp_pkg;

   localparam int PAT_MAX    = 32;
   localparam int PAT_IDX_W  = $clog2(PAT_MAX);
   localparam int PAT_LEN_W  = 6;
   localparam int PAT_BITS   = PAT_MAX * 8;
   localparam int OFF_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_A  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_B  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_C  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAT_D  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH = 3'd4;

   // request functions
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TEXT  = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_SEARCHING = 2'd0;
   localparam logic [1:0] STATUS_MATCH     = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STATUS_IGNORED   = 2'd3;

   typedef struct packed {
      logic       func;
      logic [7:0] text_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [OFF_W-1:0] match_start;
   } rsp_type;

   function automatic logic [7:0] pat_byte(input logic [PAT_BITS-1:0]  pat,
                                           input logic [PAT_IDX_W-1:0] idx);
      return pat[idx * 8 +: 8];
   endfunction

endpackage

`default_nettype wire

// File: sv/kmp_substring_matcher.sv
// ----------------------------------------------------------------------------
// KMP substring matcher
// Streams a text buffer past a configured 1 to 32 byte pattern and reports
// the offset of the first complete match.
// ----------------------------------------------------------------------------
// Send a start transaction (func 0) first: it clears the match state and
// rebuilds the failure table from the pattern registers, then returns status
// 3. Each following text transaction returns one result: 0 searching, 1 the
// match completed on this byte (match_start holds the offset of its first
// byte), 2 the last byte went by without a match, 3 ignored because the
// buffer is already done. Offsets saturate at 65535. Every transaction is
// taken while the block is idle. A text byte then needs a compare plus a
// table read per failure link followed; links amortise to at most one per
// byte. A start transaction writes entry 0, then compares and writes one
// table entry for each further pattern byte, plus a table read per link
// followed while building. The pace of both is set by the single port of
// the 32 x 5 failure table memory, which serves one read or one write per
// cycle and registers its read data. A finished result sits in the output
// register while the next transaction is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_substring_matcher (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire kmp_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output kmp_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_wr_en,
   input  wire logic [kmp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [kmp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import kmp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_BUILD = 4'b0010,
      S_TEXT  = 4'b0100,
      S_OUT   = 4'b1000
   } state_type;

   // configuration
   logic [PAT_BITS-1:0]  pat_ff, pat_in;
   logic [PAT_LEN_W-1:0] len_ff, len_in;

   // control and match state
   state_type            state_ff, state_in;
   logic                 hop_ff, hop_in;
   logic                 found_ff, found_in;
   logic [PAT_LEN_W-1:0] mlen_ff, mlen_in;
   logic [OFF_W-1:0]     offs_ff, offs_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // work registers
   logic [PAT_IDX_W-1:0] ptr_ff, ptr_in;   // j while searching, k while building
   logic [PAT_IDX_W-1:0] idx_ff, idx_in;   // i while building
   logic [7:0]           char_ff, char_in;
   logic                 last_ff, last_in;
   rsp_type              pend_ff, pend_in;
   rsp_type              rsp_ff, rsp_in;

   // failure table memory
   logic [PAT_IDX_W-1:0] ft_mem [PAT_MAX];
   logic [PAT_IDX_W-1:0] rd_ff;
   logic                 mem_we, mem_re;
   logic [PAT_IDX_W-1:0] mem_waddr, mem_wdata, mem_raddr;

   // datapath
   logic [PAT_LEN_W-1:0] eff_len;
   logic [PAT_IDX_W-1:0] last_idx;
   logic [PAT_IDX_W-1:0] cur;
   logic [7:0]           cur_byte, ref_byte;
   logic                 eq, hop_needed, matched, out_free, res_go;
   logic [PAT_LEN_W-1:0] adv;
   logic [OFF_W:0]       pos_p1;
   logic [OFF_W-1:0]     start;
   rsp_type              res;

   // length 0 acts as 1, anything above the table depth as the depth
   always_comb begin
      if (len_ff == '0) begin
         eff_len = PAT_LEN_W'(1);
      end else if (len_ff > PAT_LEN_W'(PAT_MAX)) begin
         eff_len = PAT_LEN_W'(PAT_MAX);
      end else begin
         eff_len = len_ff;
      end
   end
   assign last_idx = PAT_IDX_W'(eff_len - PAT_LEN_W'(1));

   // after a table read the pointer takes the link; a link that does not
   // shrink the pointer falls back to zero
   assign cur        = hop_ff ? ((rd_ff < ptr_ff) ? rd_ff : '0) : ptr_ff;
   assign cur_byte   = pat_byte(pat_ff, cur);
   assign ref_byte   = (state_ff == S_BUILD) ? pat_byte(pat_ff, idx_ff) : char_ff;
   assign eq         = (cur_byte == ref_byte);
   assign hop_needed = (cur != '0) && !eq;
   assign adv        = PAT_LEN_W'(cur) + PAT_LEN_W'(eq);
   assign matched    = (adv >= eff_len);
   assign pos_p1     = {1'b0, offs_ff} + (OFF_W+1)'(1);
   assign start      = (pos_p1 >= (OFF_W+1)'(eff_len))
                       ? OFF_W'(pos_p1 - (OFF_W+1)'(eff_len)) : '0;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // configuration writes
   always_comb begin
      pat_in = pat_ff;
      len_in = len_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PAT_A:  pat_in[0*CSR_DATA_W +: CSR_DATA_W] = csr_wdata;
            CSR_PAT_B:  pat_in[1*CSR_DATA_W +: CSR_DATA_W] = csr_wdata;
            CSR_PAT_C:  pat_in[2*CSR_DATA_W +: CSR_DATA_W] = csr_wdata;
            CSR_PAT_D:  pat_in[3*CSR_DATA_W +: CSR_DATA_W] = csr_wdata;
            CSR_LENGTH: len_in = csr_wdata[PAT_LEN_W-1:0];
            default:    ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      hop_in       = hop_ff;
      found_in     = found_ff;
      mlen_in      = mlen_ff;
      offs_in      = offs_ff;
      ptr_in       = ptr_ff;
      idx_in       = idx_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_raddr    = PAT_IDX_W'(cur - PAT_IDX_W'(1));
      res_go       = 1'b0;
      res          = '{status: STATUS_IGNORED, match_start: '0};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.func == FUNC_START) begin
                  // entry 0 is always zero
                  mem_we   = 1'b1;
                  mlen_in  = '0;
                  offs_in  = '0;
                  found_in = 1'b0;
                  idx_in   = PAT_IDX_W'(1);
                  ptr_in   = '0;
                  hop_in   = 1'b0;
                  if (eff_len == PAT_LEN_W'(1)) begin
                     res_go = 1'b1;
                  end else begin
                     state_in = S_BUILD;
                  end
               end else if (found_ff) begin
                  res_go = 1'b1;
               end else begin
                  char_in  = req_data.text_byte;
                  last_in  = req_data.last_byte;
                  ptr_in   = (mlen_ff > PAT_LEN_W'(last_idx)) ? last_idx
                                                                : mlen_ff[PAT_IDX_W-1:0];
                  hop_in   = 1'b0;
                  state_in = S_TEXT;
               end
            end
         end

         S_BUILD: begin
            if (hop_needed) begin
               mem_re = 1'b1;
               ptr_in = cur;
               hop_in = 1'b1;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff;
               mem_wdata = adv[PAT_IDX_W-1:0];
               ptr_in    = adv[PAT_IDX_W-1:0];
               hop_in    = 1'b0;
               if (idx_ff == last_idx) begin
                  res_go = 1'b1;
               end else begin
                  idx_in = idx_ff + PAT_IDX_W'(1);
               end
            end
         end

         S_TEXT: begin
            if (hop_needed) begin
               mem_re = 1'b1;
               ptr_in = cur;
               hop_in = 1'b1;
            end else begin
               hop_in  = 1'b0;
               res_go  = 1'b1;
               offs_in = (offs_ff == '1) ? offs_ff : offs_ff + OFF_W'(1);
               if (matched) begin
                  mlen_in   = eff_len;
                  found_in  = 1'b1;
                  res       = '{status: STATUS_MATCH, match_start: start};
               end else begin
                  mlen_in = adv;
                  if (last_ff) begin
                     found_in = 1'b1;
                     res      = '{status: STATUS_NOT_FOUND, match_start: '0};
                  end else begin
                     res      = '{status: STATUS_SEARCHING, match_start: '0};
                  end
               end
            end
         end

         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // a finished result goes straight out if the output register is free
      if (res_go) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = res;
            state_in     = S_IDLE;
         end else begin
            pend_in  = res;
            state_in = S_OUT;
         end
      end
   end

   // failure table: one read or one write per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ft_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= ft_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff       <= '0;
         len_ff       <= PAT_LEN_W'(1);
         state_ff     <= S_IDLE;
         hop_ff       <= 1'b0;
         found_ff     <= 1'b0;
         mlen_ff      <= '0;
         offs_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_ff       <= pat_in;
         len_ff       <= len_in;
         state_ff     <= state_in;
         hop_ff       <= hop_in;
         found_ff     <= found_in;
         mlen_ff      <= mlen_in;
         offs_ff      <= offs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

// File: sv/kmp_checker.sv
// ----------------------------------------------------------------------------
// KMP substring matcher checker
// Port-level properties of the matcher, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kmp_substring_matcher_defines.svh"

module kmp_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire kmp_pkg::req_type                req_data,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire kmp_pkg::rsp_type                rsp_data,
   input wire logic                            csr_wr_en,
   input wire logic [kmp_pkg::CSR_IDX_W-1:0]   csr_index,
   input wire logic [kmp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import kmp_pkg::*;

   logic       req_take, rsp_take;
   logic [1:0] outst_ff, outst_in;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign outst_in = 2'(outst_ff + 2'(req_take) - 2'(rsp_take));

   // transactions taken but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_in;
      end
   end

   `KMP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "stalled result changed or dropped")

   `KMP_ASSERT_NOW(a_start_zero, clock, reset,
      rsp_valid && (rsp_data.status != STATUS_MATCH),
      rsp_data.match_start == '0, "match_start set without a match")

   `KMP_ASSERT_NOW(a_no_spurious, clock, reset, rsp_valid, outst_ff != 2'd0,
      "result with no transaction outstanding")

   `KMP_ASSERT_NOW(a_outst_bound, clock, reset, 1'b1, outst_ff != 2'd3,
      "more than two transactions outstanding")

   // configuration and request payload are observed only
   logic unused_ok;
   assign unused_ok = csr_wr_en ^ (^csr_index) ^ (^csr_wdata) ^ (^req_data);

endmodule

bind kmp_substring_matcher kmp_checker u_kmp_checker (.*);

`default_nettype wire

// File: test/kmp_substring_matcher_test.sv
// ----------------------------------------------------------------------------
// KMP substring matcher testbench
// Drives a short table of hand-picked transactions, then random text buffers
// under three idling regimes. Every result is checked against a typed row's own
// expectation or else a cycle-free predictor of the search, kept in step with
// the register writes made by the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module kmp_substring_matcher_test;

   import kmp_pkg::*;

   // cycles without any accepted transaction before the run is abandoned
   localparam int WATCHDOG_LIMIT = 4000;
   // quiet time allowed at the end for stray results
   localparam int DRAIN_CYCLES   = 100;
   // random transactions per idling regime
   localparam int PHASE_ITEMS    = 510;

   // one row of the directed table: either a register update or a transaction
   typedef struct {
      bit                   is_cfg;
      logic [PAT_BITS-1:0]  pat;
      logic [PAT_LEN_W-1:0] len;
      req_type              item;
      bit                   typed;
      rsp_type              want;
   } dir_row_type;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_PAT_A;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // idling percentages for each side, changed between regimes
   int gap_pct   = 0;
   int stall_pct = 0;

   // byte alphabet for random buffers: small spans force failure-link hops
   int letter_base = 0;
   int letter_span = 256;

   // mirror of the block: registers and search state
   logic [PAT_BITS-1:0]  pattern_image = '0;
   logic [PAT_LEN_W-1:0] length_reg    = 6'd1;
   logic [4:0]           link_table [0:PAT_MAX-1];
   int                   run_length    = 0;
   int                   next_offset   = 0;
   bit                   buffer_closed = 1'b0;

   rsp_type     pending_results [$];
   dir_row_type directed_rows [$];

   int live_items  = 0;
   int error_count = 0;
   int idle_cycles = 0;
   bit run_done    = 1'b0;
   bit timed_out   = 1'b0;

   kmp_substring_matcher uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic logic [7:0] pattern_at(input int idx);
      return pattern_image[idx * 8 +: 8];
   endfunction

   // length register as the search sees it: 0 acts as 1, above 32 as 32
   function automatic int active_length();
      int len;
      len = int'(length_reg);
      if (len < 1) len = 1;
      if (len > PAT_MAX) len = PAT_MAX;
      return len;
   endfunction

   function automatic rsp_type predict_result(input req_type item);
      rsp_type res;
      int      m, j, f, k, i, pos, start;
      res.status      = STATUS_IGNORED;
      res.match_start = '0;
      if (item.func == FUNC_START) begin
         // rebuild the failure links from the current pattern
         m = active_length();
         k = 0;
         link_table[0] = 5'd0;
         for (i = 1; i < m; i++) begin
            while (k > 0 && pattern_at(i) != pattern_at(k)) k = int'(link_table[k - 1]);
            if (pattern_at(i) == pattern_at(k)) k++;
            link_table[i] = k[4:0];
         end
         run_length    = 0;
         next_offset   = 0;
         buffer_closed = 1'b0;
         return res;
      end
      if (buffer_closed) return res;

      // a shorter pattern written mid-buffer clamps the partial match
      m = active_length();
      j = run_length;
      if (j >= m) j = m - 1;
      while (j > 0 && pattern_at(j) != item.text_byte) begin
         f = int'(link_table[j - 1]);
         j = (f < j) ? f : 0;
      end
      if (pattern_at(j) == item.text_byte) j++;

      pos = next_offset;
      if (next_offset < 65535) next_offset++;

      if (j >= m) begin
         start           = (pos + 1 >= m) ? pos + 1 - m : 0;
         run_length      = m;
         buffer_closed   = 1'b1;
         res.status      = STATUS_MATCH;
         res.match_start = start[15:0];
      end else begin
         run_length = j;
         if (item.last_byte) begin
            buffer_closed = 1'b1;
            res.status    = STATUS_NOT_FOUND;
         end else begin
            res.status = STATUS_SEARCHING;
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers: everything changes on the falling edge
   // ---------------------------------------------------------------------

   function automatic logic [7:0] pick_byte();
      int v;
      v = letter_base + $urandom_range(0, letter_span - 1);
      return v[7:0];
   endfunction

   // one request transaction; typed rows carry their own expectation
   task automatic send_req(input req_type item, input bit typed, input rsp_type typed_result);
      rsp_type predicted;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_result(item);
      pending_results.push_back(typed ? typed_result : predicted);
      live_items++;
      @(negedge clock);
   endtask

   // valid drops here; returns once every result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // registers only change with the block idle
   task automatic program_pattern(input logic [PAT_BITS-1:0] pat,
                                  input logic [PAT_LEN_W-1:0] len);
      drain_results();
      write_csr(CSR_PAT_A, pat[63:0]);
      write_csr(CSR_PAT_B, pat[127:64]);
      write_csr(CSR_PAT_C, pat[191:128]);
      write_csr(CSR_PAT_D, pat[255:192]);
      write_csr(CSR_LENGTH, {{(CSR_DATA_W - PAT_LEN_W){1'b0}}, len});
      csr_wr_en     <= 1'b0;
      pattern_image  = pat;
      length_reg     = len;
   endtask

   function automatic void add_cfg_row(input logic [PAT_BITS-1:0] pat,
                                       input logic [PAT_LEN_W-1:0] len);
      dir_row_type row;
      row.is_cfg = 1'b1;
      row.pat    = pat;
      row.len    = len;
      row.item   = '0;
      row.typed  = 1'b0;
      row.want   = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_req_row(input logic func, input logic [7:0] text_byte,
                                       input logic last, input bit typed,
                                       input logic [1:0] status,
                                       input logic [OFF_W-1:0] match_start);
      dir_row_type row;
      row.is_cfg           = 1'b0;
      row.pat              = '0;
      row.len              = '0;
      row.item.func        = func;
      row.item.text_byte   = text_byte;
      row.item.last_byte   = last;
      row.typed            = typed;
      row.want.status      = status;
      row.want.match_start = match_start;
      directed_rows.push_back(row);
   endfunction

   // One random buffer: optional new pattern, a start, then text. Most
   // buffers are well formed and often hold the pattern; the rest drop the
   // last marker, trail bytes past the end, or stop right after the start.
   task automatic run_random_buffer();
      logic [PAT_BITS-1:0]  pat;
      logic [PAT_LEN_W-1:0] len_val;
      logic [7:0]           text [0:63];
      req_type              item;
      int                   m, n, at, i, k, flavour, roll, shift_at;
      if ($urandom_range(0, 2) == 0) begin
         roll        = $urandom_range(0, 3);
         letter_span = (roll == 0) ? 256 : roll + 1;
         letter_base = $urandom_range(0, 256 - letter_span);
         for (i = 0; i < PAT_MAX; i++) pat[i * 8 +: 8] = pick_byte();
         roll = $urandom_range(0, 99);
         if (roll < 65)      len_val = PAT_LEN_W'($urandom_range(1, 6));
         else if (roll < 85) len_val = PAT_LEN_W'($urandom_range(7, 31));
         else if (roll < 93) len_val = PAT_LEN_W'(PAT_MAX);
         else if (roll < 96) len_val = '0;
         else                len_val = PAT_LEN_W'($urandom_range(33, 63));
         program_pattern(pat, len_val);
      end
      m = active_length();
      if ($urandom_range(0, 99) < 80) n = $urandom_range(1, m + 12);
      else                            n = $urandom_range(m, 2 * m + 20);
      if (n > 64) n = 64;
      for (i = 0; i < n; i++) text[i] = pick_byte();
      if (n >= m && $urandom_range(0, 99) < 60) begin
         at = $urandom_range(0, n - m);
         for (i = 0; i < m; i++) text[at + i] = pattern_at(i);
      end
      flavour  = $urandom_range(0, 99);
      shift_at = ($urandom_range(0, 99) < 6) ? n / 2 : -1;

      // text_byte and last_byte of a start are don't-care: randomise them
      item.func      = FUNC_START;
      item.text_byte = 8'($urandom_range(0, 255));
      item.last_byte = 1'($urandom_range(0, 1));
      send_req(item, 1'b0, '0);
      if (flavour >= 95) return;

      for (i = 0; i < n; i++) begin
         if (i == shift_at) begin
            // new pattern bytes mid-buffer, length never above the built table
            for (k = 0; k < PAT_MAX; k++) pat[k * 8 +: 8] = pick_byte();
            len_val = PAT_LEN_W'($urandom_range(1, m));
            program_pattern(pat, len_val);
         end
         item.func      = FUNC_TEXT;
         item.text_byte = text[i];
         item.last_byte = (i == n - 1) && (flavour < 80 || flavour >= 88);
         send_req(item, 1'b0, '0);
      end
      if (flavour >= 88) begin
         for (k = $urandom_range(1, 3); k > 0; k--) begin
            item.func      = FUNC_TEXT;
            item.text_byte = 8'($urandom_range(0, 255));
            item.last_byte = 1'($urandom_range(0, 1));
            send_req(item, 1'b0, '0);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: stall on the falling edge, sample on the rising edge
   // ---------------------------------------------------------------------

   always @(negedge clock) rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   task automatic report_mismatch(input string what, input int want, input int got);
      error_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result: expected none, actual status %0d start %0d",
                        $time, rsp_data.status, rsp_data.match_start);
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", want.status, rsp_data.status);
               if (rsp_data.match_start !== want.match_start)
                  report_mismatch("match_start", want.match_start, rsp_data.match_start);
            end
         end
      end
      // watchdog: any accepted transaction on either channel counts as progress
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      int target, i;

      // default pattern: one zero byte
      add_req_row(FUNC_START, 8'h00, 1'b0, 1'b1, STATUS_IGNORED, 16'd0);
      add_req_row(FUNC_TEXT,  8'h00, 1'b0, 1'b1, STATUS_MATCH,   16'd0);
      add_req_row(FUNC_TEXT,  8'hFF, 1'b1, 1'b1, STATUS_IGNORED, 16'd0);
      // longest pattern, all ones: builds every link, then hops back to zero
      add_cfg_row({32{8'hFF}}, 6'd32);
      add_req_row(FUNC_START, 8'hFF, 1'b1, 1'b1, STATUS_IGNORED, 16'd0);
      add_req_row(FUNC_TEXT,  8'hFF, 1'b0, 1'b0, STATUS_SEARCHING, 16'd0);
      add_req_row(FUNC_TEXT,  8'hFF, 1'b0, 1'b0, STATUS_SEARCHING, 16'd0);
      add_req_row(FUNC_TEXT,  8'h00, 1'b0, 1'b0, STATUS_SEARCHING, 16'd0);
      add_req_row(FUNC_TEXT,  8'hFF, 1'b1, 1'b0, STATUS_SEARCHING, 16'd0);
      // "AAB": match after a failure link, then a byte after the match
      add_cfg_row({232'd0, 8'h42, 8'h41, 8'h41}, 6'd3);
      add_req_row(FUNC_START, 8'h00, 1'b0, 1'b1, STATUS_IGNORED, 16'd0);
      add_req_row(FUNC_TEXT,  8'h41, 1'b0, 1'b0, STATUS_SEARCHING, 16'd0);
      add_req_row(FUNC_TEXT,  8'h41, 1'b0, 1'b0, STATUS_SEARCHING, 16'd0);
      add_req_row(FUNC_TEXT,  8'h41, 1'b0, 1'b0, STATUS_SEARCHING, 16'd0);
      add_req_row(FUNC_TEXT,  8'h42, 1'b0, 1'b0, STATUS_SEARCHING, 16'd0);
      add_req_row(FUNC_TEXT,  8'h41, 1'b1, 1'b1, STATUS_IGNORED, 16'd0);
      // length beyond the maximum, then shortened mid-buffer
      add_cfg_row({232'd0, 8'h42, 8'h41, 8'h41}, 6'd63);
      add_req_row(FUNC_START, 8'h00, 1'b0, 1'b1, STATUS_IGNORED, 16'd0);
      add_req_row(FUNC_TEXT,  8'h41, 1'b0, 1'b0, STATUS_SEARCHING, 16'd0);
      add_req_row(FUNC_TEXT,  8'h41, 1'b0, 1'b0, STATUS_SEARCHING, 16'd0);
      add_cfg_row({232'd0, 8'h42, 8'h41, 8'h41}, 6'd2);
      add_req_row(FUNC_TEXT,  8'h41, 1'b0, 1'b0, STATUS_SEARCHING, 16'd0);
      // zero length acts as one byte; a match on the last byte still reports
      add_cfg_row({8'hA5, 224'd0, 8'h5A, 8'h00, 8'hFF}, 6'd0);
      add_req_row(FUNC_START, 8'h00, 1'b0, 1'b1, STATUS_IGNORED, 16'd0);
      add_req_row(FUNC_TEXT,  8'hFF, 1'b1, 1'b1, STATUS_MATCH,   16'd0);
      add_req_row(FUNC_START, 8'h00, 1'b0, 1'b1, STATUS_IGNORED, 16'd0);
      add_req_row(FUNC_TEXT,  8'h7E, 1'b1, 1'b1, STATUS_NOT_FOUND, 16'd0);

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // regime one: sender idles more rarely than the receiver stalls
      gap_pct   = 34;
      stall_pct = 45;
      for (i = 0; i < directed_rows.size(); i++) begin
         if (directed_rows[i].is_cfg)
            program_pattern(directed_rows[i].pat, directed_rows[i].len);
         else
            send_req(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end
      target = live_items + PHASE_ITEMS;
      while (live_items < target) run_random_buffer();

      // regime two: the other way round
      gap_pct   = 45;
      stall_pct = 34;
      target = live_items + PHASE_ITEMS;
      while (live_items < target) run_random_buffer();

      // regime three: back to back on both sides
      gap_pct   = 0;
      stall_pct = 0;
      target = live_items + PHASE_ITEMS;
      while (live_items < target) run_random_buffer();

      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      run_done = 1'b1;
   end

   initial begin
      wait (run_done || timed_out);
      if (timed_out)
         $display("%0t: watchdog: no transaction for %0d cycles, %0d results outstanding",
                  $time, WATCHDOG_LIMIT, pending_results.size());
      if (!timed_out && error_count == 0 && pending_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/kmp_pkg.sv
sv/kmp_substring_matcher.sv
sv/kmp_checker.sv
test/kmp_substring_matcher_test.sv
